FILE: rtl/group_commit_log_controller_defines.svh
// Assertion helpers used by the checker file.
`ifndef GROUP_COMMIT_LOG_CONTROLLER_DEFINES_SVH
`define GROUP_COMMIT_LOG_CONTROLLER_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define GLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glc: same-cycle check failed");

// Next-cycle implication, held off while reset is low.
`define GLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glc: next-cycle check failed");

`endif

FILE: rtl/glc_pkg.sv
`timescale 1ns / 1ps
package glc_pkg;

  localparam int LOG_ENTRIES_DEF = 32;

  localparam int ACT_W = 6;
  localparam int RES_W = 6;
  localparam logic [ACT_W-1:0] ACTIVE_MAX = ACT_W'(63);

  localparam logic [7:0]  REGION_RST  = 8'd33;
  localparam logic [5:0]  RESERVE_RST = 6'd10;
  localparam logic [31:0] HEADER_RST  = 32'd0;

  typedef enum logic [1:0] {
    CFG_REGION  = 2'd0,
    CFG_RESERVE = 2'd1,
    CFG_HEADER  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_END    = 2'd1,
    OP_RECORD = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    STAT_GRANTED        = 4'd0,
    STAT_WAIT_COMMIT    = 4'd1,
    STAT_WAIT_SPACE     = 4'd2,
    STAT_NEW            = 4'd3,
    STAT_ABSORBED       = 4'd4,
    STAT_RELEASED       = 4'd5,
    STAT_COMMIT_ENTRY   = 4'd6,
    STAT_COMMIT_EMPTY   = 4'd7,
    STAT_FINISHED       = 4'd8,
    STAT_FULL           = 4'd9,
    STAT_OUTSIDE        = 4'd10,
    STAT_BUSY_COMMIT    = 4'd11,
    STAT_UNDERFLOW      = 4'd12,
    STAT_NOT_COMMITTING = 4'd13
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EMIT = 2'd2
  } state_t;

  typedef struct packed {
    logic [7:0]  region_blocks;
    logic [5:0]  reserve_per_op;
    logic [31:0] header_block;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] home_block;
    logic [31:0] log_addr;
    logic        last;
    logic        wake;
  } res_t;

endpackage

FILE: rtl/glc_table.sv
`timescale 1ns / 1ps
module glc_table #(
  parameter int DEPTH  = glc_pkg::LOG_ENTRIES_DEF,
  parameter int ADDR_W = $clog2(glc_pkg::LOG_ENTRIES_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data
);
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/glc_ctrl.sv
`timescale 1ns / 1ps
module glc_ctrl #(
  parameter int LOG_ENTRIES = glc_pkg::LOG_ENTRIES_DEF,
  parameter int ADDR_W      = $clog2(glc_pkg::LOG_ENTRIES_DEF)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  glc_pkg::cfg_t     cfg,
  input  logic              start,
  input  logic [1:0]        in_operation,
  input  logic [31:0]       in_block_number,
  output logic              busy,
  output logic              mem_wr_en,
  output logic [ADDR_W-1:0] mem_wr_addr,
  output logic [31:0]       mem_wr_data,
  output logic              mem_rd_en,
  output logic [ADDR_W-1:0] mem_rd_addr,
  input  logic [31:0]       mem_rd_data,
  output logic              res_valid,
  output glc_pkg::res_t     res
);
  import glc_pkg::*;

  localparam int CNT_W  = $clog2(LOG_ENTRIES + 1);
  localparam int PROD_W = ACT_W + 1 + RES_W;
  localparam int NEED_W = ((PROD_W > CNT_W) ? PROD_W : CNT_W) + 1;
  localparam int FULL_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ACT_W-1:0]  active_r, active_nxt;
  logic              commit_r, commit_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pidx_r, pidx_nxt;
  logic [31:0]       key_r, key_nxt;
  logic              res_valid_r, res_valid_nxt;
  res_t              res_r, res_nxt;

  op_t               op;
  logic              accept;
  logic [ACT_W:0]    act_inc;
  logic [PROD_W-1:0] prod;
  logic [NEED_W-1:0] need;
  logic              no_room;
  logic              is_full;
  logic              go_emit;
  logic              go_scan;
  logic              scan_hit;
  logic              pend_last;
  logic [ADDR_W-1:0] slot_sel;
  logic [31:0]       slot_addr;

  assign op     = op_t'(in_operation);
  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // worst-case reservation check for a begin request
  assign act_inc = {1'b0, active_r} + (ACT_W + 1)'(1);
  assign prod    = PROD_W'(act_inc) * PROD_W'(cfg.reserve_per_op);
  assign need    = NEED_W'(count_r) + NEED_W'(prod);
  assign no_room = (need > NEED_W'(LOG_ENTRIES)) || (active_r == ACTIVE_MAX);

  assign is_full = (count_r >= CNT_W'(LOG_ENTRIES)) ||
                   ((FULL_W'(count_r) + FULL_W'(1)) >= FULL_W'(cfg.region_blocks));

  assign go_emit = (op == OP_END) && !commit_r && (active_r == ACT_W'(1)) &&
                   (count_r != '0);
  assign go_scan = (op == OP_RECORD) && !is_full && (active_r != '0) &&
                   (count_r != '0);

  assign scan_hit  = (mem_rd_data == key_r);
  assign pend_last = ((CNT_W'(pidx_r) + CNT_W'(1)) == count_r);

  // one adder shared by every result that carries a log address
  always_comb begin
    if (state_r == S_IDLE) begin
      slot_sel = '0;
    end else if (state_r == S_SCAN && !scan_hit) begin
      slot_sel = count_r[ADDR_W-1:0];
    end else begin
      slot_sel = pidx_r;
    end
  end
  assign slot_addr = cfg.header_block + 32'(slot_sel) + 32'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && go_emit) begin
          state_nxt = S_EMIT;
        end else if (accept && go_scan) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pend_r && (scan_hit || pend_last)) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (pend_r && pend_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    active_nxt    = active_r;
    commit_nxt    = commit_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    key_nxt       = key_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = count_r[ADDR_W-1:0];
    mem_wr_data   = key_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = ptr_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{STAT_GRANTED, 32'd0, 32'd0, 1'b1, 1'b0};
          ptr_nxt       = '0;
          case (op)
            OP_BEGIN: begin
              if (commit_r) begin
                res_nxt.status = STAT_WAIT_COMMIT;
              end else if (no_room) begin
                res_nxt.status = STAT_WAIT_SPACE;
              end else begin
                active_nxt = active_r + ACT_W'(1);
              end
            end
            OP_END: begin
              if (commit_r) begin
                res_nxt.status = STAT_BUSY_COMMIT;
              end else if (active_r == '0) begin
                res_nxt.status = STAT_UNDERFLOW;
              end else begin
                active_nxt = active_r - ACT_W'(1);
                if (active_r != ACT_W'(1)) begin
                  res_nxt.status = STAT_RELEASED;
                  res_nxt.wake   = 1'b1;
                end else begin
                  commit_nxt = 1'b1;
                  if (count_r == '0) begin
                    res_nxt.status = STAT_COMMIT_EMPTY;
                  end else begin
                    // entries follow from the emit loop
                    res_valid_nxt = 1'b0;
                  end
                end
              end
            end
            OP_RECORD: begin
              if (is_full) begin
                res_nxt.status = STAT_FULL;
              end else if (active_r == '0) begin
                res_nxt.status = STAT_OUTSIDE;
              end else if (count_r == '0) begin
                mem_wr_en          = 1'b1;
                mem_wr_addr        = '0;
                mem_wr_data        = in_block_number;
                count_nxt          = CNT_W'(1);
                res_nxt.status     = STAT_NEW;
                res_nxt.home_block = in_block_number;
                res_nxt.log_addr   = slot_addr;
              end else begin
                key_nxt       = in_block_number;
                res_valid_nxt = 1'b0;
              end
            end
            OP_FINISH: begin
              if (!commit_r) begin
                res_nxt.status = STAT_NOT_COMMITTING;
              end else begin
                count_nxt      = '0;
                commit_nxt     = 1'b0;
                res_nxt.status = STAT_FINISHED;
                res_nxt.wake   = 1'b1;
              end
            end
            default: res_nxt.status = STAT_NOT_COMMITTING;
          endcase
        end
      end
      S_SCAN: begin
        if (pend_r && scan_hit) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{STAT_ABSORBED, key_r, slot_addr, 1'b1, 1'b0};
        end else if (pend_r && pend_last) begin
          mem_wr_en     = 1'b1;
          count_nxt     = count_r + CNT_W'(1);
          res_valid_nxt = 1'b1;
          res_nxt       = '{STAT_NEW, key_r, slot_addr, 1'b1, 1'b0};
        end
      end
      S_EMIT: begin
        if (pend_r) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{STAT_COMMIT_ENTRY, mem_rd_data, slot_addr, pend_last, 1'b0};
        end
      end
      default: res_valid_nxt = 1'b0;
    endcase

    // read pipeline: one entry issued per cycle while the loop runs on
    if ((state_r != S_IDLE) && (state_nxt == state_r) && (ptr_r < count_r)) begin
      mem_rd_en = 1'b1;
      pend_nxt  = 1'b1;
      pidx_nxt  = ptr_r[ADDR_W-1:0];
      ptr_nxt   = ptr_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      active_r    <= '0;
      commit_r    <= 1'b0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      commit_r    <= commit_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    key_r  <= key_nxt;
    res_r  <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/group_commit_log_controller.sv
`timescale 1ns / 1ps
// Group-commit redo log controller: admission and block table bookkeeping.
// Input: pulse start with in_operation / in_block_number while busy is low;
//   the request is taken at that edge. busy stays high while a record search
//   or a commit emission runs.
// Output: out_valid marks each result for exactly one cycle; there is no
//   back-pressure, the receiver must take every result as it appears.
// Config: cfg_valid / cfg_ready write channel, cfg_ready always high; index 0
//   log region size, 1 reservation per operation, 2 log header block.
//   Write only while idle.
// Results: begin, finish, error and non-final end requests give one result
//   the cycle after acceptance. A record that must search is paced by the
//   single registered read port of the block table, one entry compared per
//   cycle. The final end streams one commit entry per cycle, paced by the
//   table read port, each entry via the read and result registers, last
//   flagged by out_last; an empty table gives one COMMIT_EMPTY result.
// Reset: counters and commit flag clear, registers take their defaults; the
//   table contents need no clearing as only filled slots are ever read.
module group_commit_log_controller #(
  parameter int LOG_ENTRIES = glc_pkg::LOG_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_block_number,
  output logic        out_valid,
  output logic [3:0]  out_status,
  output logic [31:0] out_home_block,
  output logic [31:0] out_log_addr,
  output logic        out_last,
  output logic        out_wake_waiters,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import glc_pkg::*;

  localparam int ADDR_W = $clog2(LOG_ENTRIES);

  cfg_t              cfg_r;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [31:0]       mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [31:0]       mem_rd_data;
  logic              res_valid;
  res_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{REGION_RST, RESERVE_RST, HEADER_RST};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REGION:  cfg_r.region_blocks  <= cfg_data[7:0];
        CFG_RESERVE: cfg_r.reserve_per_op <= cfg_data[5:0];
        CFG_HEADER:  cfg_r.header_block   <= cfg_data;
        default:     cfg_r <= cfg_r;
      endcase
    end
  end

  glc_ctrl #(
    .LOG_ENTRIES (LOG_ENTRIES),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .start           (start),
    .in_operation    (in_operation),
    .in_block_number (in_block_number),
    .busy            (busy),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data),
    .res_valid       (res_valid),
    .res             (res)
  );

  glc_table #(
    .DEPTH  (LOG_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign out_valid        = res_valid;
  assign out_status       = res.status;
  assign out_home_block   = res.home_block;
  assign out_log_addr     = res.log_addr;
  assign out_last         = res.last;
  assign out_wake_waiters = res.wake;

endmodule

FILE: rtl/glc_checker.sv
`timescale 1ns / 1ps
`include "group_commit_log_controller_defines.svh"
module glc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic [3:0]  out_status,
  input logic [31:0] out_home_block,
  input logic [31:0] out_log_addr,
  input logic        out_last,
  input logic        out_wake_waiters
);
  import glc_pkg::*;

  // begin and finish requests answer in the very next cycle, single result
  `GLC_ASSERT_NXT(a_quick_reply, clk, rst_n, start && !busy && (in_operation == OP_BEGIN || in_operation == OP_FINISH), out_valid && out_last && !busy)

  // waiters are only woken by a release or a finished commit
  `GLC_ASSERT_IMP(a_wake_src, clk, rst_n, out_valid && out_wake_waiters, out_status == STAT_RELEASED || out_status == STAT_FINISHED)

  // only commit entries are ever non-final
  `GLC_ASSERT_IMP(a_last_only_entry, clk, rst_n, out_valid && !out_last, out_status == STAT_COMMIT_ENTRY)

  // a commit stream has no gaps
  `GLC_ASSERT_NXT(a_stream_dense, clk, rst_n, out_valid && !out_last, out_valid && out_status == STAT_COMMIT_ENTRY)

  // block fields are zero on results that carry no table entry
  `GLC_ASSERT_IMP(a_zero_fields, clk, rst_n, out_valid && out_status != STAT_COMMIT_ENTRY && out_status != STAT_NEW && out_status != STAT_ABSORBED, out_home_block == 32'd0 && out_log_addr == 32'd0)

endmodule

bind group_commit_log_controller glc_checker u_glc_checker (.*);
